/* rtl/mpsa_pkg.sv */
// Shared types, codes and helpers for the masked pixel / scalar ALU.
// No dependencies; imported by masked_pixel_scalar_alu and the testbench.
package mpsa_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int QW = 32;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_LE  = 3'd4;
	localparam logic [2:0] OP_GE  = 3'd5;

	localparam logic [2:0] REG_OPERATION = 3'd0;
	localparam logic [2:0] REG_PIX_CPLX  = 3'd1;
	localparam logic [2:0] REG_CON_CPLX  = 3'd2;
	localparam logic [2:0] REG_CON_REAL  = 3'd3;
	localparam logic [2:0] REG_CON_IMAG  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_UNSUP   = 2'd2;
	localparam logic [1:0] ST_SAT     = 2'd3;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} clamp_t;

	// per-item control carried along the divider stages
	typedef struct packed {
		logic [31:0] res_re;
		logic [31:0] res_im;
		logic [1:0]  st;
		logic        is_div;
		logic        neg_re;
		logic        neg_im;
		logic        ovf_re;
		logic        ovf_im;
	} carry_t;

	// saturate a sign/magnitude value into a signed 32-bit word
	function automatic clamp_t clamp_mag(input logic neg, input logic [64:0] mag);
		clamp_t r;
		r.sat = 1'b0;
		if (!neg) begin
			if (mag > 65'h0_7FFF_FFFF) begin
				r.sat = 1'b1;
				r.val = 32'h7FFF_FFFF;
			end else begin
				r.val = mag[31:0];
			end
		end else begin
			if (mag > 65'h0_8000_0000) begin
				r.sat = 1'b1;
				r.val = 32'h8000_0000;
			end else begin
				r.val = 32'd0 - mag[31:0];
			end
		end
		return r;
	endfunction

	// saturate an exact 33-bit signed sum
	function automatic clamp_t clamp_sum(input logic signed [32:0] s);
		clamp_t r;
		r.sat = (s[32] != s[31]);
		if (!r.sat) r.val = s[31:0];
		else if (s[32]) r.val = 32'h8000_0000;
		else r.val = 32'h7FFF_FFFF;
		return r;
	endfunction

endpackage

/* rtl/masked_pixel_scalar_alu.sv */
// Masked pixel / scalar ALU: add, subtract, multiply, divide and threshold of a
// real or complex Q pixel against a configured constant. Uses mpsa_pkg.
// Pipeline: 3 front stages, 32 divider stages and an output register between input
// beat and output beat. Throughput: one beat per cycle; the whole pipe
// advances together and holds when the output beat is not taken.
// The divider retires one quotient bit per stage for each of the two parts.
// Reset (arst_n low, asynchronous) clears all valid bits and config registers.
module masked_pixel_scalar_alu #(
	parameter int FRACTION_BITS = mpsa_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] pixel_real, [63:32] pixel_imag
	input  logic        s_axis_tuser,   // [0] pixel_valid (mask)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] result_real, [63:32] result_imag
	output logic [2:0]  m_axis_tuser    // [0] result_is_complex, [2:1] status
);
	import mpsa_pkg::*;

	localparam int SH = QW - FRACTION_BITS;   // X>>32 == mag>>SH, X = mag<<F

	// ---------------- configuration registers ----------------
	logic [2:0]         op_q;
	logic               pcx_q, ccx_q;
	logic signed [31:0] cre_q, cim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= OP_ADD;
			pcx_q <= 1'b0;
			ccx_q <= 1'b0;
			cre_q <= '0;
			cim_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OPERATION: op_q  <= cfg_data[2:0];
				REG_PIX_CPLX:  pcx_q <= cfg_data[0];
				REG_CON_CPLX:  ccx_q <= cfg_data[0];
				REG_CON_REAL:  cre_q <= cfg_data;
				REG_CON_IMAG:  cim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic cplx;
	assign cplx = pcx_q | ccx_q;

	// global advance: the pipe moves whenever the output slot is free or drains
	logic en, out_vld_q;
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- stage 1: products ----------------
	logic signed [31:0] pr_in, pi_in, ci_eff;
	assign pr_in  = s_axis_tdata[31:0];
	assign pi_in  = pcx_q ? s_axis_tdata[63:32] : 32'sd0;
	assign ci_eff = ccx_q ? cim_q : 32'sd0;

	logic               vld_s1, mask_s1;
	logic signed [31:0] pr_s1, pi_s1;
	logic signed [63:0] pa_s1, pb_s1, pc_s1, pd_s1, dd1_s1, dd2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mask_s1 <= s_axis_tuser;
			pr_s1   <= pr_in;
			pi_s1   <= pi_in;
			pa_s1   <= pr_in * cre_q;
			pb_s1   <= pi_in * ci_eff;
			pc_s1   <= pr_in * ci_eff;
			pd_s1   <= pi_in * cre_q;
			dd1_s1  <= cre_q * cre_q;
			dd2_s1  <= ci_eff * ci_eff;
		end
	end

	// ---------------- stage 2: sums, add/sub, threshold ----------------
	logic signed [64:0] a65, b65, c65, d65;
	assign a65 = 65'(pa_s1);
	assign b65 = 65'(pb_s1);
	assign c65 = 65'(pc_s1);
	assign d65 = 65'(pd_s1);

	logic               vld_s2, mask_s2, thr_s2;
	logic signed [64:0] sre_s2, sim_s2;
	logic [63:0]        den_s2;
	clamp_t             asre_s2, asim_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mask_s2 <= mask_s1;
			// multiply: p*c ; divide: p*conj(c)
			sre_s2  <= (op_q == OP_MUL) ? a65 - b65 : a65 + b65;
			sim_s2  <= (op_q == OP_MUL) ? c65 + d65 : d65 - c65;
			den_s2  <= 64'(dd1_s1) + 64'(dd2_s1);
			if (op_q == OP_SUB) begin
				asre_s2 <= clamp_sum(33'(pr_s1) - 33'(cre_q));
				asim_s2 <= clamp_sum(33'(pi_s1) - 33'(ci_eff));
			end else begin
				asre_s2 <= clamp_sum(33'(pr_s1) + 33'(cre_q));
				asim_s2 <= clamp_sum(33'(pi_s1) + 33'(ci_eff));
			end
			thr_s2  <= (op_q == OP_LE) ? (pr_s1 <= cre_q) : (cre_q <= pr_s1);
		end
	end

	// ---------------- stage 3: rounding, select, divider setup ----------------
	logic        neg_re, neg_im;
	logic [63:0] mag_re, mag_im;
	logic [64:0] rnd_re, rnd_im;
	clamp_t      mre, mim;
	carry_t      c3;

	assign neg_re = sre_s2[64];
	assign neg_im = sim_s2[64];
	assign mag_re = neg_re ? 64'(-sre_s2) : sre_s2[63:0];
	assign mag_im = neg_im ? 64'(-sim_s2) : sim_s2[63:0];
	// round to nearest, ties away from zero, on the magnitude
	assign rnd_re = ({1'b0, mag_re} + (65'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
	assign rnd_im = ({1'b0, mag_im} + (65'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
	assign mre    = clamp_mag(neg_re, rnd_re);
	assign mim    = clamp_mag(neg_im, rnd_im);

	always_comb begin
		c3        = '0;
		c3.neg_re = neg_re;
		c3.neg_im = neg_im;
		c3.ovf_re = (mag_re >> SH) >= den_s2;
		c3.ovf_im = (mag_im >> SH) >= den_s2;
		if (mask_s2) begin
			unique case (op_q) inside
				OP_ADD, OP_SUB: begin
					c3.res_re = asre_s2.val;
					c3.res_im = asim_s2.val;
					c3.st     = (asre_s2.sat || asim_s2.sat) ? ST_SAT : ST_OK;
				end
				OP_MUL: begin
					c3.res_re = mre.val;
					c3.res_im = mim.val;
					c3.st     = (mre.sat || mim.sat) ? ST_SAT : ST_OK;
				end
				OP_DIV: begin
					if (den_s2 == 64'd0) begin
						// constant zero: a nonzero part goes to the limit of its sign, a zero part to zero
						c3.st     = ST_DIVZERO;
						c3.res_re = (mag_re == 64'd0) ? 32'd0 :
							(neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF);
						c3.res_im = (mag_im == 64'd0) ? 32'd0 :
							(neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF);
					end else begin
						c3.is_div = 1'b1;
					end
				end
				OP_LE, OP_GE: begin
					if (cplx) c3.st = ST_UNSUP;
					else if (thr_s2) c3.res_re = 32'd1 << FRACTION_BITS;
				end
				default: c3.st = ST_UNSUP;
			endcase
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	// Partial remainder starts at X>>32 (below den unless overflow); the low 32
	// numerator bits are fed in MSB first.
	logic               dv_vld_sk [QW+1];
	carry_t             dv_c_sk   [QW+1];
	logic [63:0]        dv_den_sk [QW+1];
	logic [63:0]        dv_pre_sk [QW+1];
	logic [63:0]        dv_pim_sk [QW+1];
	logic [QW-1:0]      dv_xre_sk [QW+1];
	logic [QW-1:0]      dv_xim_sk [QW+1];
	logic [QW-1:0]      dv_qre_sk [QW+1];
	logic [QW-1:0]      dv_qim_sk [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_vld_sk[0] <= 1'b0;
		else if (en) dv_vld_sk[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_c_sk[0]   <= c3;
			dv_den_sk[0] <= den_s2;
			dv_pre_sk[0] <= mag_re >> SH;
			dv_pim_sk[0] <= mag_im >> SH;
			dv_xre_sk[0] <= mag_re[QW-1:0] << FRACTION_BITS;
			dv_xim_sk[0] <= mag_im[QW-1:0] << FRACTION_BITS;
			dv_qre_sk[0] <= '0;
			dv_qim_sk[0] <= '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [63:0] tre, tim;
		logic        gre, gim;
		assign tre = {dv_pre_sk[k][62:0], dv_xre_sk[k][QW-1]};
		assign tim = {dv_pim_sk[k][62:0], dv_xim_sk[k][QW-1]};
		assign gre = tre >= dv_den_sk[k];
		assign gim = tim >= dv_den_sk[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_sk[k+1] <= 1'b0;
			else if (en) dv_vld_sk[k+1] <= dv_vld_sk[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_c_sk[k+1]   <= dv_c_sk[k];
				dv_den_sk[k+1] <= dv_den_sk[k];
				dv_pre_sk[k+1] <= gre ? tre - dv_den_sk[k] : tre;
				dv_pim_sk[k+1] <= gim ? tim - dv_den_sk[k] : tim;
				dv_xre_sk[k+1] <= dv_xre_sk[k] << 1;
				dv_xim_sk[k+1] <= dv_xim_sk[k] << 1;
				dv_qre_sk[k+1] <= {dv_qre_sk[k][QW-2:0], gre};
				dv_qim_sk[k+1] <= {dv_qim_sk[k][QW-2:0], gim};
			end
		end
	end

	// ---------------- output register ----------------
	carry_t      cf;
	clamp_t      qre, qim;
	logic [31:0] fin_re, fin_im;
	logic [1:0]  fin_st;

	assign cf  = dv_c_sk[QW];
	assign qre = clamp_mag(cf.neg_re, 65'(dv_qre_sk[QW]));
	assign qim = clamp_mag(cf.neg_im, 65'(dv_qim_sk[QW]));

	always_comb begin
		fin_re = cf.res_re;
		fin_im = cf.res_im;
		fin_st = cf.st;
		if (cf.is_div) begin
			fin_re = cf.ovf_re ? (cf.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF) : qre.val;
			fin_im = cf.ovf_im ? (cf.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF) : qim.val;
			fin_st = (cf.ovf_re || cf.ovf_im || qre.sat || qim.sat) ? ST_SAT : ST_OK;
		end
	end

	logic [63:0] out_data_q;
	logic [1:0]  out_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= dv_vld_sk[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {fin_im, fin_re};
			out_st_q   <= fin_st;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = {out_st_q, cplx};

	// ---------------- checks ----------------
	a_divzero_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:1] == ST_DIVZERO |-> op_q == OP_DIV)
		else $error("divide-by-zero status outside divide");

	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:1] == ST_UNSUP |-> m_axis_tdata == 64'd0)
		else $error("unsupported beat carries data");

	a_real_imag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[63:32] == 32'd0)
		else $error("real result with nonzero imaginary part");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dv_vld_sk[QW]) && $stable(vld_s1))
		else $error("pipe moved during stall");

endmodule

/* verif/testbench.sv */
// Self-checking bench for masked_pixel_scalar_alu: pixel beats in, result beats checked
// against an in-bench arithmetic predictor. Depends on rtl/mpsa_pkg.sv and the block RTL.
`timescale 1ns / 100ps

module testbench;
	import mpsa_pkg::*;

	localparam int FB         = FRACTION_BITS_DEF;
	localparam int PIPE_DEPTH = 36;       // registers from input beat to output beat in the block
	localparam int CYCLE_CAP  = 400000;   // far above the slowest legal run

	// operation codes with no defined function
	localparam logic [2:0] OP_RSV_LO = 3'd6;
	localparam logic [2:0] OP_RSV_HI = 3'd7;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic        cplx;
		logic [1:0]  st;
	} pix_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // [31:0] pixel_real, [63:32] pixel_imag
	logic        s_axis_tuser = 1'b0; // [0] pixel_valid (mask)
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // [31:0] result_real, [63:32] result_imag
	logic [2:0]  m_axis_tuser;        // [0] result_is_complex, [2:1] status

	masked_pixel_scalar_alu dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// shadow of the block's configuration registers
	logic [2:0]  cur_op = OP_ADD;
	logic        cur_pix_cplx = 1'b0;
	logic        cur_con_cplx = 1'b0;
	logic [31:0] cur_con_re = '0;
	logic [31:0] cur_con_im = '0;

	pix_result_t pending_results[$];
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycles = 0;
	int unsigned pixels_sent = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned divzero_seen = 0, sat_seen = 0, unsup_seen = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("masked_pixel_scalar_alu regression: fail");
			$finish;
		end
	end

	// receiver back-pressure, changed on the falling edge
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// ---------------- predictor ----------------

	function automatic logic [31:0] clamp_mag32(input logic neg, input logic [79:0] mag,
			inout logic sat);
		if (!neg) begin
			if (mag > 80'h7FFF_FFFF) begin
				sat = 1'b1;
				return 32'h7FFF_FFFF;
			end
			return mag[31:0];
		end
		if (mag > 80'h8000_0000) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return 32'd0 - mag[31:0];
	endfunction

	function automatic logic [31:0] sum_sat(input logic signed [65:0] s, inout logic sat);
		logic neg;
		neg = s < 0;
		return clamp_mag32(neg, neg ? 80'(-s) : 80'(s), sat);
	endfunction

	// round to nearest, ties away from zero
	function automatic logic [31:0] prod_round(input logic signed [65:0] p, inout logic sat);
		logic neg;
		logic [79:0] mag;
		neg = p < 0;
		mag = neg ? 80'(-p) : 80'(p);
		mag = (mag + (80'd1 << (FB - 1))) >> FB;
		return clamp_mag32(neg, mag, sat);
	endfunction

	// truncating quotient num * 2^FB / den, den > 0
	function automatic logic [31:0] quot_trunc(input logic signed [65:0] num,
			input logic [65:0] den, inout logic sat);
		logic neg;
		logic [127:0] mag;
		logic [127:0] q;
		neg = num < 0;
		mag = neg ? 128'(-num) : 128'(num);
		q = (mag << FB) / 128'(den);
		if (q > 128'hFFFF_FFFF) begin
			sat = 1'b1;
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return clamp_mag32(neg, q[79:0], sat);
	endfunction

	// constant of zero: rail toward the numerator sign, zero for a zero numerator
	function automatic logic [31:0] zero_div_rail(input logic signed [65:0] num);
		if (num == 0) return 32'd0;
		return (num < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	function automatic pix_result_t compute_pixel(input logic mask, input logic [31:0] re,
			input logic [31:0] im);
		pix_result_t r;
		logic signed [65:0] pr, pi, cr, ci, a, b, c, d;
		logic [65:0] den;
		logic sat;
		r.re = '0;
		r.im = '0;
		r.st = ST_OK;
		r.cplx = cur_pix_cplx | cur_con_cplx;
		sat = 1'b0;
		pr = {{34{re[31]}}, re};
		pi = cur_pix_cplx ? {{34{im[31]}}, im} : 66'sd0;
		cr = {{34{cur_con_re[31]}}, cur_con_re};
		ci = cur_con_cplx ? {{34{cur_con_im[31]}}, cur_con_im} : 66'sd0;
		if (!mask) return r;
		case (cur_op) inside
			OP_ADD: begin
				r.re = sum_sat(pr + cr, sat);
				r.im = sum_sat(pi + ci, sat);
			end
			OP_SUB: begin
				r.re = sum_sat(pr - cr, sat);
				r.im = sum_sat(pi - ci, sat);
			end
			OP_MUL: begin
				r.re = prod_round(pr * cr - pi * ci, sat);
				r.im = prod_round(pr * ci + pi * cr, sat);
			end
			OP_DIV: begin
				// p * conj(c) / |c|^2
				a = pr * cr + pi * ci;
				b = pi * cr - pr * ci;
				den = 66'(cr * cr + ci * ci);
				if (den == 0) begin
					r.re = zero_div_rail(a);
					r.im = zero_div_rail(b);
					r.st = ST_DIVZERO;
				end else begin
					r.re = quot_trunc(a, den, sat);
					r.im = quot_trunc(b, den, sat);
				end
			end
			OP_LE, OP_GE: begin
				c = pr;
				d = cr;
				if (r.cplx) r.st = ST_UNSUP;
				else if (cur_op == OP_LE ? (c <= d) : (d <= c)) r.re = 32'd1 << FB;
			end
			default: r.st = ST_UNSUP;
		endcase
		if (sat && r.st == ST_OK) r.st = ST_SAT;
		return r;
	endfunction

	// ---------------- result checker ----------------

	always @(posedge clk) begin
		pix_result_t want, got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.re = m_axis_tdata[31:0];
			got.im = m_axis_tdata[63:32];
			got.cplx = m_axis_tuser[0];
			got.st = m_axis_tuser[2:1];
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat re=%h im=%h cplx=%b st=%0d",
					$time, got.re, got.im, got.cplx, got.st);
			end else begin
				want = pending_results.pop_front();
				if (want.st == ST_DIVZERO) divzero_seen++;
				if (want.st == ST_SAT) sat_seen++;
				if (want.st == ST_UNSUP) unsup_seen++;
				if (got.re !== want.re) begin
					mismatches++;
					$display("%0t: result_real expected %h actual %h", $time, want.re, got.re);
				end
				if (got.im !== want.im) begin
					mismatches++;
					$display("%0t: result_imag expected %h actual %h", $time, want.im, got.im);
				end
				if (got.cplx !== want.cplx) begin
					mismatches++;
					$display("%0t: result_is_complex expected %b actual %b",
						$time, want.cplx, got.cplx);
				end
				if (got.st !== want.st) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
				end
			end
		end
	end

	// ---------------- drivers ----------------

	// one pixel beat; valid stays high afterwards so back-to-back beats have no gap
	task automatic send_pixel(input logic mask, input logic [31:0] re, input logic [31:0] im);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mask;
		s_axis_tdata <= {im, re};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(compute_pixel(mask, re, im));
		pixels_sent++;
	endtask

	task automatic stop_pixels();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// stop sending, wait for every pending result, then let the pipe settle
	task automatic drain();
		stop_pixels();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_OPERATION: cur_op = value[2:0];
			REG_PIX_CPLX:  cur_pix_cplx = value[0];
			REG_CON_CPLX:  cur_con_cplx = value[0];
			REG_CON_REAL:  cur_con_re = value;
			REG_CON_IMAG:  cur_con_im = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// block must be idle here; upper data bits are junk the block should ignore
	task automatic set_mode(input logic [2:0] op, input logic pcx, input logic ccx,
			input logic [31:0] cre, input logic [31:0] cim);
		drain();
		write_reg(REG_OPERATION, {29'($urandom_range(0, 32'h1FFF_FFFF)), op});
		write_reg(REG_PIX_CPLX, {31'($urandom_range(0, 32'h7FFF_FFFF)), pcx});
		write_reg(REG_CON_CPLX, {31'($urandom_range(0, 32'h7FFF_FFFF)), ccx});
		write_reg(REG_CON_REAL, cre);
		write_reg(REG_CON_IMAG, cim);
	endtask

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 9)) inside
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3, 4: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;   // about +-8.0
			5: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;      // about +-512
			6: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;  // +-1.0
			default: return $urandom;
		endcase
	endfunction

	// ---------------- tests ----------------

	task automatic test_directed();
		// reset config: real add of zero
		send_pixel(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(1'b0, 32'h1234_5678, 32'h0);
		set_mode(OP_ADD, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
		send_pixel(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);   // both parts saturate
		send_pixel(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
		set_mode(OP_SUB, 1'b0, 1'b1, 32'h8000_0000, 32'h0001_0000);
		send_pixel(1'b1, 32'h7FFF_FFFF, 32'h5555_5555);
		send_pixel(1'b0, 32'h7FFF_FFFF, 32'h5555_5555);   // masked
		set_mode(OP_MUL, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000);
		send_pixel(1'b1, 32'h8000_0000, 32'h8000_0000);   // largest magnitude product
		send_pixel(1'b1, 32'h0000_8000, 32'hFFFF_8000);
		set_mode(OP_MUL, 1'b1, 1'b1, 32'h0000_8000, 32'h0);
		send_pixel(1'b1, 32'h0000_0001, 32'hFFFF_FFFF);
		set_mode(OP_DIV, 1'b1, 1'b1, 32'h0, 32'h0);       // divide by zero
		send_pixel(1'b1, 32'h0001_0000, 32'hFFFF_0000);
		send_pixel(1'b1, 32'h0, 32'h0);
		set_mode(OP_DIV, 1'b0, 1'b1, 32'h0000_0001, 32'h0);
		send_pixel(1'b1, 32'h7FFF_FFFF, 32'h0);           // quotient overflow
		set_mode(OP_DIV, 1'b1, 1'b1, 32'h0003_0000, 32'hFFFC_0000);
		send_pixel(1'b1, 32'h0007_0000, 32'h0002_8000);
		set_mode(OP_LE, 1'b0, 1'b0, 32'h0002_0000, 32'h1);
		send_pixel(1'b1, 32'h0002_0000, 32'h0);           // equal
		send_pixel(1'b1, 32'h0002_0001, 32'h0);
		set_mode(OP_GE, 1'b0, 1'b0, 32'h8000_0000, 32'h0);
		send_pixel(1'b1, 32'h8000_0000, 32'h0);
		send_pixel(1'b1, 32'h7FFF_FFFF, 32'h0);
		set_mode(OP_GE, 1'b1, 1'b0, 32'h0, 32'h0);        // threshold on complex: unsupported
		send_pixel(1'b1, 32'h1, 32'h1);
		set_mode(OP_RSV_LO, 1'b0, 1'b0, 32'h1, 32'h1);
		send_pixel(1'b1, 32'h1, 32'h1);
		set_mode(OP_RSV_HI, 1'b0, 1'b1, 32'h1, 32'h1);
		send_pixel(1'b1, 32'h1, 32'h1);
		send_pixel(1'b0, 32'h1, 32'h1);
	endtask

	task automatic test_random();
		int unsigned per_mode [4][2] = '{'{0, 0}, '{62, 0}, '{0, 62}, '{8, 8}};
		logic [2:0] op;
		for (int ph = 0; ph < 16; ph++) begin
			op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(OP_RSV_LO, OP_RSV_HI)) :
				3'($urandom_range(OP_ADD, OP_GE));
			if (ph == 1) set_mode(op, 1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
			else if (ph == 2) set_mode(OP_DIV, 1'($urandom_range(0, 1)), 1'b0, 32'h0, $urandom);
			else if (ph == 3) set_mode(OP_LE, 1'b0, 1'b0, rand_q(), $urandom);
			else set_mode(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				rand_q(), rand_q());
			idle_pct = per_mode[ph % 4][0];
			stall_pct = per_mode[ph % 4][1];
			for (int n = 0; n < 118; n++) begin
				if (ph == 8 && n == 60) drain();   // sender holds until the pipe is empty
				send_pixel($urandom_range(0, 99) < 88, rand_q(), rand_q());
			end
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		drain();
		$display("pixels sent %0d, results checked %0d over 16 random modes and 4 idle mixes",
			pixels_sent, results_seen);
		$display("status seen: divide-by-zero %0d, saturated %0d, unsupported %0d",
			divzero_seen, sat_seen, unsup_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("masked_pixel_scalar_alu regression: pass");
		end else begin
			$display("masked_pixel_scalar_alu regression: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/mpsa_pkg.sv
rtl/masked_pixel_scalar_alu.sv
verif/testbench.sv
